[rtl/core/rhmp_pkg.sv]
// Package for the readout hit/marker parser core.
// Holds parameter defaults, field widths, mode and status codes, and shared types.
// No dependencies.
`default_nettype none

package rhmp_pkg;

   localparam int NUM_CARDS_DEF    = 16;
   localparam int CHIPS_NARROW_DEF = 32;
   localparam int CHIPS_WIDE_DEF   = 32;

   localparam int WORD_W   = 64;
   localparam int FEC_W    = 5;
   localparam int STAMP_W  = 52;
   localparam int TRIG_W   = 42;
   localparam int COUNT_W  = 16;
   localparam int TNUM_W   = 17;
   localparam int ROW_W    = 17;

   localparam logic [STAMP_W:0] WRAP_GAP = 53'h1FFFFFFF;

   typedef enum logic [1:0] {
      MODE_STANDARD = 2'd0,
      MODE_TRIGGER  = 2'd1,
      MODE_WIDE     = 2'd2,
      MODE_RELATIVE = 2'd3
   } mode_type;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_SEQ_ERR = 2'd1;
   localparam logic [1:0] STATUS_WRAP    = 2'd2;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic [TRIG_W-1:0]  trig;
      logic [STAMP_W-1:0] stamp;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic               is_hit;
      logic [7:0]         chip_id;
      logic [5:0]         channel;
      logic [9:0]         adc_value;
      logic [7:0]         tdc_value;
      logic [11:0]        bunch_id;
      logic               over_threshold;
      logic [14:0]        time_offset;
      logic [STAMP_W-1:0] marker_stamp;
      logic [TRIG_W-1:0]  trigger_stamp;
      logic [TNUM_W-1:0]  trigger_number;
      logic [1:0]         marker_status;
   } rsp_type;

endpackage

`default_nettype wire

[rtl/core/readout_hit_marker_parser_core.sv]
// Top level of the readout hit/marker parser: decode, marker table RMW, result register.
// Depends on rhmp_pkg and rhmp_ram.
`default_nettype none

// Channel   Ports                         Direction  Handshake
// req       req_readout_word, req_fec_id  in         req_valid / req_ready
// rsp       rsp_* result fields           out        rsp_valid / rsp_ready
// csr       csr_wdata (format mode)       in         csr_we, no wait
//
// One item per cycle sustained while rsp is not stalled; rsp_valid rises when the item
// has passed both registers, the table read (s1) and the modify/write-back into the result
// register.
// Read-after-write on the same row is covered by a one-entry write forward.
// After reset the table is cleared one row per cycle, all NumCards * max(ChipsNarrow,
// ChipsWide) rows (512 by default), with req_ready low; csr writes are taken.
// A stalled rsp holds the pipe; req_ready drops once s1 holds an item behind the stalled result register.

module readout_hit_marker_parser_core
   import rhmp_pkg::*;
#(
   parameter int NumCards    = NUM_CARDS_DEF,
   parameter int ChipsNarrow = CHIPS_NARROW_DEF,
   parameter int ChipsWide   = CHIPS_WIDE_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [WORD_W-1:0]  req_readout_word,
   input  wire logic [FEC_W-1:0]   req_fec_id,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic                    rsp_is_hit,
   output logic [7:0]              rsp_chip_id,
   output logic [5:0]              rsp_channel,
   output logic [9:0]              rsp_adc_value,
   output logic [7:0]              rsp_tdc_value,
   output logic [11:0]             rsp_bunch_id,
   output logic                    rsp_over_threshold,
   output logic [14:0]             rsp_time_offset,
   output logic [STAMP_W-1:0]      rsp_marker_stamp,
   output logic [TRIG_W-1:0]       rsp_trigger_stamp,
   output logic [TNUM_W-1:0]       rsp_trigger_number,
   output logic [1:0]              rsp_marker_status,
   input  wire logic               csr_we,
   input  wire logic [1:0]         csr_wdata
);

   localparam int RowChips = (ChipsNarrow > ChipsWide) ? ChipsNarrow : ChipsWide;
   localparam int Depth    = NumCards * RowChips;
   localparam int AddrW    = (Depth > 1) ? $clog2(Depth) : 1;

   function automatic logic [11:0] gray12(input logic [11:0] g);
      logic [11:0] b;
      b = g;
      b = b ^ (b >> 1);
      b = b ^ (b >> 2);
      b = b ^ (b >> 4);
      b = b ^ (b >> 8);
      return b;
   endfunction

   function automatic logic [1:0] seq_status(input logic [STAMP_W-1:0] old_v,
                                             input logic [STAMP_W-1:0] new_v);
      logic [STAMP_W:0] lim;
      logic [1:0]       st;
      lim = {1'b0, new_v} + WRAP_GAP;
      st  = STATUS_OK;
      if (old_v > new_v) begin
         st = ({1'b0, old_v} < lim) ? STATUS_SEQ_ERR : STATUS_WRAP;
      end
      return st;
   endfunction

   // chip modulo tables
   logic [4:0] narrow_mod [32];
   logic [7:0] wide_mod   [256];

   for (genvar i = 0; i < 32; i++) begin : g_nmod
      assign narrow_mod[i] = 5'(i % ChipsNarrow);
   end
   for (genvar i = 0; i < 256; i++) begin : g_wmod
      assign wide_mod[i] = 8'(i % ChipsWide);
   end

   mode_type            mode_ff;
   logic                clearing_ff;
   logic [AddrW-1:0]    clr_addr_ff;

   logic                s1_valid_ff;
   logic [WORD_W-1:0]   s1_word_ff;
   logic                s1_ok_ff;
   logic [AddrW-1:0]    s1_addr_ff;

   logic                fwd_valid_ff;
   logic [AddrW-1:0]    fwd_addr_ff;
   entry_type           fwd_data_ff;

   rsp_type             rsp_ff;
   rsp_type             rsp_in;
   logic                rsp_valid_ff;

   logic                accept;
   logic                s1_adv;
   logic                fec_ok;
   logic [7:0]          chip_mod;
   logic [ROW_W-1:0]    row_full;
   logic [AddrW-1:0]    rd_addr;

   entry_type           ram_rdata;
   entry_type           old_entry;
   entry_type           new_entry;
   logic                tbl_we;

   logic                ram_we;
   logic [AddrW-1:0]    ram_waddr;
   entry_type           ram_wdata;

   // stage 0: row select
   assign fec_ok = (req_fec_id != '0) && ({4'b0, req_fec_id} <= 9'(NumCards));

   always_comb begin
      if (mode_ff == MODE_WIDE) begin
         chip_mod = wide_mod[req_readout_word[59:52]];
         row_full = ROW_W'(req_fec_id - 5'd1) * ROW_W'(ChipsWide) + ROW_W'(chip_mod);
      end else begin
         if (req_readout_word[15]) begin
            chip_mod = {3'b0, narrow_mod[req_readout_word[42:38]]};
         end else begin
            chip_mod = {3'b0, narrow_mod[req_readout_word[14:10]]};
         end
         row_full = ROW_W'(req_fec_id - 5'd1) * ROW_W'(ChipsNarrow) + ROW_W'(chip_mod);
      end
   end

   assign rd_addr   = row_full[AddrW-1:0];
   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !clearing_ff && (!s1_valid_ff || s1_adv);
   assign accept    = req_valid && req_ready;

   assign ram_we    = clearing_ff || tbl_we;
   assign ram_waddr = clearing_ff ? clr_addr_ff : s1_addr_ff;
   assign ram_wdata = clearing_ff ? entry_type'('0) : new_entry;

   rhmp_ram #(
      .Width (ENTRY_W),
      .Depth (Depth)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (accept),
      .raddr (rd_addr),
      .rdata (ram_rdata)
   );

   // stage 1: modify
   assign old_entry = (fwd_valid_ff && (fwd_addr_ff == s1_addr_ff)) ? fwd_data_ff : ram_rdata;

   always_comb begin
      logic [31:0]       w1;
      logic [15:0]       w2;
      logic [TRIG_W-1:0] stamp42;
      logic              has_marker;
      w1         = s1_word_ff[47:16];
      w2         = s1_word_ff[15:0];
      stamp42    = {w1, w2[9:0]};
      has_marker = s1_ok_ff && (old_entry.stamp != '0);
      rsp_in     = '0;
      new_entry  = old_entry;
      tbl_we     = 1'b0;
      if (mode_ff == MODE_WIDE) begin
         if (s1_word_ff[63:60] != 4'h0) begin
            rsp_in.is_hit         = 1'b1;
            rsp_in.chip_id        = s1_word_ff[59:52];
            rsp_in.channel        = s1_word_ff[13:8];
            rsp_in.adc_value      = s1_word_ff[24:15];
            rsp_in.tdc_value      = s1_word_ff[7:0];
            rsp_in.bunch_id       = s1_word_ff[36:25];
            rsp_in.over_threshold = s1_word_ff[14];
            rsp_in.time_offset    = s1_word_ff[51:37];
            if (has_marker) begin
               rsp_in.marker_stamp = old_entry.stamp;
            end
         end else if (s1_ok_ff) begin
            rsp_in.marker_status = seq_status(old_entry.stamp, s1_word_ff[51:0]);
            new_entry.stamp      = s1_word_ff[51:0];
            tbl_we               = s1_adv;
         end
      end else if (w2[15]) begin
         rsp_in.is_hit         = 1'b1;
         rsp_in.chip_id        = {3'b0, w1[26:22]};
         rsp_in.channel        = w2[13:8];
         rsp_in.adc_value      = w1[21:12];
         rsp_in.tdc_value      = w2[7:0];
         rsp_in.bunch_id       = gray12(w1[11:0]);
         rsp_in.over_threshold = w2[14];
         rsp_in.time_offset    = {10'b0, w1[31:27]};
         if (has_marker) begin
            rsp_in.marker_stamp   = old_entry.stamp;
            rsp_in.trigger_stamp  = old_entry.trig;
            rsp_in.trigger_number = {1'b0, old_entry.count} + 17'd1;
         end
      end else if (s1_ok_ff) begin
         if (w2[14]) begin
            if (mode_ff == MODE_TRIGGER) begin
               if (w1[31:28] == 4'hF) begin
                  new_entry.count = {w1[5:0], w2[9:0]};
               end else begin
                  new_entry.trig = stamp42;
               end
               tbl_we = s1_adv;
            end
         end else if (mode_ff == MODE_STANDARD) begin
            rsp_in.marker_status = seq_status(old_entry.stamp, STAMP_W'(stamp42));
            new_entry.stamp      = STAMP_W'(stamp42);
            tbl_we               = s1_adv;
         end else if (stamp42[TRIG_W-1:12] == '0) begin
            new_entry.stamp = STAMP_W'(stamp42);
            tbl_we          = s1_adv;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_STANDARD;
         clearing_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            mode_ff <= mode_type'(csr_wdata);
         end
         if (clearing_ff) begin
            clr_addr_ff <= clr_addr_ff + AddrW'(1);
            if (clr_addr_ff == AddrW'(Depth - 1)) begin
               clearing_ff <= 1'b0;
            end
         end
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (tbl_we) begin
            fwd_valid_ff <= 1'b1;
         end
         if (s1_adv) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_word_ff <= req_readout_word;
         s1_ok_ff   <= fec_ok;
         s1_addr_ff <= rd_addr;
      end
      if (tbl_we) begin
         fwd_addr_ff <= s1_addr_ff;
         fwd_data_ff <= new_entry;
      end
      if (s1_adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_is_hit         = rsp_ff.is_hit;
   assign rsp_chip_id        = rsp_ff.chip_id;
   assign rsp_channel        = rsp_ff.channel;
   assign rsp_adc_value      = rsp_ff.adc_value;
   assign rsp_tdc_value      = rsp_ff.tdc_value;
   assign rsp_bunch_id       = rsp_ff.bunch_id;
   assign rsp_over_threshold = rsp_ff.over_threshold;
   assign rsp_time_offset    = rsp_ff.time_offset;
   assign rsp_marker_stamp   = rsp_ff.marker_stamp;
   assign rsp_trigger_stamp  = rsp_ff.trigger_stamp;
   assign rsp_trigger_number = rsp_ff.trigger_number;
   assign rsp_marker_status  = rsp_ff.marker_status;

endmodule

`default_nettype wire

[rtl/core/rhmp_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rhmp_ram #(
   parameter  int Width = 8,
   parameter  int Depth = 2,
   localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AddrW-1:0] waddr,
   input  wire logic [Width-1:0] wdata,
   input  wire logic             re,
   input  wire logic [AddrW-1:0] raddr,
   output logic      [Width-1:0] rdata
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

[verif/rhmp_result_monitor.sv]
`timescale 1ns / 1ps
// Result monitor for the readout hit/marker parser: tracks the format mode and its own
// marker tables, predicts each rsp transfer from req transfers and compares field by field.
// Depends on rhmp_pkg.

module rhmp_result_monitor
   import rhmp_pkg::*;
#(
   parameter int NumCards    = NUM_CARDS_DEF,
   parameter int ChipsNarrow = CHIPS_NARROW_DEF,
   parameter int ChipsWide   = CHIPS_WIDE_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [WORD_W-1:0]  req_readout_word,
   input  logic [FEC_W-1:0]   req_fec_id,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic               rsp_is_hit,
   input  logic [7:0]         rsp_chip_id,
   input  logic [5:0]         rsp_channel,
   input  logic [9:0]         rsp_adc_value,
   input  logic [7:0]         rsp_tdc_value,
   input  logic [11:0]        rsp_bunch_id,
   input  logic               rsp_over_threshold,
   input  logic [14:0]        rsp_time_offset,
   input  logic [STAMP_W-1:0] rsp_marker_stamp,
   input  logic [TRIG_W-1:0]  rsp_trigger_stamp,
   input  logic [TNUM_W-1:0]  rsp_trigger_number,
   input  logic [1:0]         rsp_marker_status,
   input  logic               csr_we,
   input  logic [1:0]         csr_wdata,
   output int                 mismatches,
   output int                 outstanding,
   output int                 hits_seen,
   output int                 markers_seen,
   output int                 seq_errs_seen,
   output int                 wraps_seen
);

   localparam int RowChips     = (ChipsNarrow > ChipsWide) ? ChipsNarrow : ChipsWide;
   localparam int Depth        = NumCards * RowChips;
   localparam int TrigChipBase = 16;
   localparam int RelStampMax  = 4096;
   localparam int MaxReports   = 100;

   logic [STAMP_W-1:0] stamp_mem [Depth];
   logic [TRIG_W-1:0]  trig_mem  [Depth];
   logic [COUNT_W-1:0] count_mem [Depth];
   mode_type           mode_q;
   rsp_type            expected_rsps [$];

   initial begin
      mismatches    = 0;
      outstanding   = 0;
      hits_seen     = 0;
      markers_seen  = 0;
      seq_errs_seen = 0;
      wraps_seen    = 0;
   end

   function automatic logic [11:0] gray_to_bin(input logic [11:0] g);
      logic [11:0] b;
      b[11] = g[11];
      for (int i = 10; i >= 0; i--) b[i] = b[i+1] ^ g[i];
      return b;
   endfunction

   function automatic bit row_lookup(input logic [FEC_W-1:0] fec, input int chip,
                                     input int chips, output int row);
      row = 0;
      if (fec < 1 || fec > NumCards) return 1'b0;
      row = (int'(fec) - 1) * chips + (chip % chips);
      return row < Depth;
   endfunction

   function automatic logic [1:0] store_stamp(input int row, input logic [STAMP_W-1:0] s);
      logic [1:0] status;
      status = STATUS_OK;
      if (stamp_mem[row] > s)
         status = (64'(stamp_mem[row]) < 64'(WRAP_GAP) + 64'(s)) ? STATUS_SEQ_ERR : STATUS_WRAP;
      stamp_mem[row] = s;
      return status;
   endfunction

   function automatic rsp_type predict_result(input logic [WORD_W-1:0] word,
                                              input logic [FEC_W-1:0] fec);
      rsp_type           r;
      int                row;
      int                chip;
      bit                ok;
      logic [31:0]       w1;
      logic [15:0]       w2;
      logic [TRIG_W-1:0] st42;
      r = '0;
      if (mode_q == MODE_WIDE) begin
         chip = int'(word[59:52]);
         ok = row_lookup(fec, chip, ChipsWide, row);
         if (word[63:60] != 4'h0) begin
            r.is_hit         = 1'b1;
            r.chip_id        = word[59:52];
            r.channel        = word[13:8];
            r.adc_value      = word[24:15];
            r.tdc_value      = word[7:0];
            r.bunch_id       = word[36:25];
            r.over_threshold = word[14];
            r.time_offset    = word[51:37];
            if (ok && stamp_mem[row] != '0) r.marker_stamp = stamp_mem[row];
         end else if (ok) begin
            r.marker_status = store_stamp(row, word[51:0]);
         end
         return r;
      end
      w1   = word[47:16];
      w2   = word[15:0];
      st42 = {w1, w2[9:0]};
      if (w2[15]) begin
         chip = int'(w1[26:22]);
         ok = row_lookup(fec, chip, ChipsNarrow, row);
         r.is_hit         = 1'b1;
         r.chip_id        = 8'(w1[26:22]);
         r.channel        = w2[13:8];
         r.adc_value      = w1[21:12];
         r.tdc_value      = w2[7:0];
         r.bunch_id       = gray_to_bin(w1[11:0]);
         r.over_threshold = w2[14];
         r.time_offset    = 15'(w1[31:27]);
         if (ok && stamp_mem[row] != '0) begin
            r.marker_stamp   = stamp_mem[row];
            r.trigger_stamp  = trig_mem[row];
            r.trigger_number = {1'b0, count_mem[row]} + 17'd1;
         end
         return r;
      end
      chip = int'(w2[14:10]);
      ok = row_lookup(fec, chip, ChipsNarrow, row);
      if (!ok) return r;
      if (chip >= TrigChipBase) begin
         if (mode_q == MODE_TRIGGER) begin
            if (w1[31:28] == 4'hF) count_mem[row] = {w1[5:0], w2[9:0]};
            else trig_mem[row] = st42;
         end
      end else if (mode_q == MODE_STANDARD) begin
         r.marker_status = store_stamp(row, STAMP_W'(st42));
      end else if (st42 < RelStampMax) begin
         stamp_mem[row] = STAMP_W'(st42);
      end
      return r;
   endfunction

   task automatic compare_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= MaxReports)
            $display("%0t rsp %s mismatch: expected %0h actual %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < Depth; i++) begin
            stamp_mem[i] = '0;
            trig_mem[i]  = '0;
            count_mem[i] = '0;
         end
         mode_q = MODE_STANDARD;
         expected_rsps.delete();
      end else begin
         if (csr_we) mode_q = mode_type'(csr_wdata);
         if (rsp_valid && rsp_ready) begin
            got = {rsp_is_hit, rsp_chip_id, rsp_channel, rsp_adc_value, rsp_tdc_value,
                   rsp_bunch_id, rsp_over_threshold, rsp_time_offset, rsp_marker_stamp,
                   rsp_trigger_stamp, rsp_trigger_number, rsp_marker_status};
            if (expected_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= MaxReports)
                  $display("%0t unexpected rsp transfer: expected none actual %h", $time, got);
            end else begin
               want = expected_rsps.pop_front();
               compare_field("is_hit",         want.is_hit,         got.is_hit);
               compare_field("chip_id",        want.chip_id,        got.chip_id);
               compare_field("channel",        want.channel,        got.channel);
               compare_field("adc_value",      want.adc_value,      got.adc_value);
               compare_field("tdc_value",      want.tdc_value,      got.tdc_value);
               compare_field("bunch_id",       want.bunch_id,       got.bunch_id);
               compare_field("over_threshold", want.over_threshold, got.over_threshold);
               compare_field("time_offset",    want.time_offset,    got.time_offset);
               compare_field("marker_stamp",   want.marker_stamp,   got.marker_stamp);
               compare_field("trigger_stamp",  want.trigger_stamp,  got.trigger_stamp);
               compare_field("trigger_number", want.trigger_number, got.trigger_number);
               compare_field("marker_status",  want.marker_status,  got.marker_status);
               if (want.is_hit) hits_seen++;
               else markers_seen++;
               if (want.marker_status == STATUS_SEQ_ERR) seq_errs_seen++;
               if (want.marker_status == STATUS_WRAP) wraps_seen++;
            end
         end
         if (req_valid && req_ready)
            expected_rsps.push_back(predict_result(req_readout_word, req_fec_id));
      end
      outstanding <= expected_rsps.size();
   end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// Top of the readout hit/marker parser testbench: clock, reset, req/rsp/csr stimulus,
// watchdog and verdict. Depends on rhmp_pkg, readout_hit_marker_parser_core, rhmp_result_monitor.

module tb_top;
   import rhmp_pkg::*;

   localparam int StallLimit    = 5000;
   localparam int LongHold      = 300;
   localparam int ItemsPerPhase = 130;
   localparam int RandomPhases  = 8;
   localparam int DrainCycles   = 8;

   logic               clock            = 1'b0;
   logic               reset            = 1'b1;
   logic               req_valid        = 1'b0;
   logic [WORD_W-1:0]  req_readout_word = '0;
   logic [FEC_W-1:0]   req_fec_id       = '0;
   logic               rsp_ready        = 1'b0;
   logic               csr_we           = 1'b0;
   logic [1:0]         csr_wdata        = '0;

   logic               req_ready;
   logic               rsp_valid;
   logic               rsp_is_hit;
   logic [7:0]         rsp_chip_id;
   logic [5:0]         rsp_channel;
   logic [9:0]         rsp_adc_value;
   logic [7:0]         rsp_tdc_value;
   logic [11:0]        rsp_bunch_id;
   logic               rsp_over_threshold;
   logic [14:0]        rsp_time_offset;
   logic [STAMP_W-1:0] rsp_marker_stamp;
   logic [TRIG_W-1:0]  rsp_trigger_stamp;
   logic [TNUM_W-1:0]  rsp_trigger_number;
   logic [1:0]         rsp_marker_status;

   int mismatches, outstanding, hits_seen, markers_seen, seq_errs_seen, wraps_seen;

   int          req_run     = 0;
   int          rsp_run     = 0;
   int          items_sent  = 0;
   int          mode_writes = 0;
   logic [63:0] stamp_now   = 64'd0;
   mode_type    cur_mode    = MODE_STANDARD;

   always #1 clock = ~clock;

   readout_hit_marker_parser_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_readout_word   (req_readout_word),
      .req_fec_id         (req_fec_id),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_is_hit         (rsp_is_hit),
      .rsp_chip_id        (rsp_chip_id),
      .rsp_channel        (rsp_channel),
      .rsp_adc_value      (rsp_adc_value),
      .rsp_tdc_value      (rsp_tdc_value),
      .rsp_bunch_id       (rsp_bunch_id),
      .rsp_over_threshold (rsp_over_threshold),
      .rsp_time_offset    (rsp_time_offset),
      .rsp_marker_stamp   (rsp_marker_stamp),
      .rsp_trigger_stamp  (rsp_trigger_stamp),
      .rsp_trigger_number (rsp_trigger_number),
      .rsp_marker_status  (rsp_marker_status),
      .csr_we             (csr_we),
      .csr_wdata          (csr_wdata)
   );

   rhmp_result_monitor result_mon (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_readout_word   (req_readout_word),
      .req_fec_id         (req_fec_id),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_is_hit         (rsp_is_hit),
      .rsp_chip_id        (rsp_chip_id),
      .rsp_channel        (rsp_channel),
      .rsp_adc_value      (rsp_adc_value),
      .rsp_tdc_value      (rsp_tdc_value),
      .rsp_bunch_id       (rsp_bunch_id),
      .rsp_over_threshold (rsp_over_threshold),
      .rsp_time_offset    (rsp_time_offset),
      .rsp_marker_stamp   (rsp_marker_stamp),
      .rsp_trigger_stamp  (rsp_trigger_stamp),
      .rsp_trigger_number (rsp_trigger_number),
      .rsp_marker_status  (rsp_marker_status),
      .csr_we             (csr_we),
      .csr_wdata          (csr_wdata),
      .mismatches         (mismatches),
      .outstanding        (outstanding),
      .hits_seen          (hits_seen),
      .markers_seen       (markers_seen),
      .seq_errs_seen      (seq_errs_seen),
      .wraps_seen         (wraps_seen)
   );

   // idle cycles before the next transfer; occasional runs with no idling
   function automatic int draw_gap(inout int run_left);
      if (run_left > 0) begin
         run_left--;
         return 0;
      end
      if ($urandom_range(0, 49) == 0) begin
         run_left = $urandom_range(20, 40);
         return 0;
      end
      return $urandom_range(0, 13);
   endfunction

   function automatic logic [63:0] narrow_hit(input int chip);
      logic [63:0] w;
      w = {$urandom, $urandom};
      w[15] = 1'b1;
      w[42:38] = 5'(chip);
      return w;
   endfunction

   function automatic logic [63:0] narrow_marker(input int chip, input logic [63:0] s);
      logic [63:0] w;
      w = {$urandom, $urandom};
      w[47:16] = s[41:10];
      w[15] = 1'b0;
      w[14:10] = 5'(chip);
      w[9:0] = s[9:0];
      return w;
   endfunction

   function automatic logic [63:0] count_marker(input int chip);
      logic [63:0] w;
      w = narrow_marker(chip, {$urandom, $urandom});
      w[47:44] = 4'hF;
      return w;
   endfunction

   function automatic logic [63:0] wide_hit(input int chip);
      logic [63:0] w;
      w = {$urandom, $urandom};
      w[63:60] = 4'($urandom_range(1, 15));
      w[59:52] = 8'(chip);
      return w;
   endfunction

   function automatic logic [63:0] wide_marker(input int chip, input logic [63:0] s);
      return {4'h0, 8'(chip), s[51:0]};
   endfunction

   // mostly rising stamps, with steps back, small values, jumps and restarts
   function automatic logic [63:0] next_stamp();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: begin
            stamp_now += $urandom_range(1, 5000);
            return stamp_now;
         end
         6: return stamp_now - $urandom_range(1, 1000);
         7: return 64'($urandom_range(0, 4095));
         8: begin
            stamp_now = {$urandom, $urandom};
            return stamp_now;
         end
         default: begin
            stamp_now = 64'($urandom_range(0, 100));
            return stamp_now;
         end
      endcase
   endfunction

   task automatic send_item(input logic [63:0] w, input logic [FEC_W-1:0] f);
      int gap;
      gap = draw_gap(req_run);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_readout_word <= w;
      req_fec_id       <= f;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_mode(input mode_type m);
      csr_we    <= 1'b1;
      csr_wdata <= m;
      @(posedge clock);
      csr_we    <= 1'b0;
      cur_mode = m;
      mode_writes++;
   endtask

   task automatic send_random_item();
      int               kind;
      int               lo_chip;
      int               hi_chip;
      int               hit_chip;
      int               wide_ofs;
      logic [FEC_W-1:0] fec;
      logic [63:0]      w;
      int               lo_pool [3];
      int               hi_pool [3];
      logic [FEC_W-1:0] fec_pool [3];
      lo_pool  = '{0, 5, 15};
      hi_pool  = '{16, 20, 31};
      fec_pool = '{5'd1, 5'd7, 5'd16};
      kind     = $urandom_range(0, 99);
      fec      = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(1, NUM_CARDS_DEF))
                                              : fec_pool[$urandom_range(0, 2)];
      lo_chip  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                              : lo_pool[$urandom_range(0, 2)];
      hi_chip  = ($urandom_range(0, 3) == 0) ? $urandom_range(16, 31)
                                              : hi_pool[$urandom_range(0, 2)];
      hit_chip = $urandom_range(0, 1) ? lo_chip : hi_chip;
      wide_ofs = 32 * $urandom_range(0, 7);
      if (kind < 40) begin
         w = (cur_mode == MODE_WIDE) ? wide_hit(hit_chip + wide_ofs) : narrow_hit(hit_chip);
      end else if (kind < 70) begin
         w = (cur_mode == MODE_WIDE) ? wide_marker(lo_chip + wide_ofs, next_stamp())
                                     : narrow_marker(lo_chip, next_stamp());
      end else if (kind < 85) begin
         if (cur_mode == MODE_WIDE) w = wide_marker(hi_chip + wide_ofs, next_stamp());
         else if ($urandom_range(0, 1)) w = count_marker(hi_chip);
         else w = narrow_marker(hi_chip, {$urandom, $urandom});
      end else begin
         w   = {$urandom, $urandom};
         fec = 5'($urandom);
      end
      send_item(w, fec);
   endtask

   // receiver: random back-pressure, two long hold-offs to fill the pipe
   initial begin
      int gap;
      int taken;
      taken = 0;
      forever begin
         if (taken == 150 || taken == 700) gap = LongHold;
         else gap = draw_gap(rsp_run);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         taken++;
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < StallLimit) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("%0t watchdog: no transfer for %0d cycles", $time, StallLimit);
      $display("FAIL");
      $finish;
   end

   initial begin
      mode_type phase_order [4];
      mode_type m;
      phase_order = '{MODE_STANDARD, MODE_RELATIVE, MODE_WIDE, MODE_TRIGGER};
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      write_mode(MODE_STANDARD);
      send_item(64'hFFFF_FFFF_FFFF_FFFF, 5'd16);
      send_item(64'h0000_0000_0000_8000, 5'd1);
      send_item(narrow_marker(5, 64'd1000), 5'd16);
      send_item(narrow_hit(5), 5'd16);
      send_item(narrow_marker(5, 64'd500), 5'd16);
      send_item(narrow_marker(5, 64'h3FF_FFFF_FFFF), 5'd16);
      send_item(narrow_marker(5, 64'd1), 5'd16);
      send_item(narrow_marker(5, 64'd7), 5'd0);
      send_item(narrow_hit(5), 5'd0);
      send_item(narrow_hit(5), 5'd17);
      send_item(narrow_marker(20, 64'd99), 5'd16);
      send_item(narrow_hit(20), 5'd16);
      wait_idle();

      write_mode(MODE_TRIGGER);
      send_item(narrow_marker(3, 64'd100), 5'd2);
      send_item(narrow_marker(4, 64'd4096), 5'd2);
      send_item(narrow_hit(4), 5'd2);
      send_item(count_marker(20), 5'd2);
      send_item(narrow_marker(20, 64'h123_4567_89AB), 5'd2);
      send_item(narrow_hit(3), 5'd2);
      wait_idle();

      write_mode(MODE_WIDE);
      send_item(wide_marker(84, 64'hF_FFFF_FFFF_FFFF), 5'd2);
      send_item(64'hF54F_FFFF_FFFF_FFFF, 5'd2);
      send_item(wide_marker(84, 64'd0), 5'd2);
      send_item(wide_marker(84, 64'h123), 5'd2);
      wait_idle();

      write_mode(MODE_RELATIVE);
      send_item(narrow_marker(0, 64'd4095), 5'd3);
      send_item(narrow_hit(0), 5'd3);
      send_item(narrow_hit(20), 5'd2);

      for (int p = 0; p < RandomPhases; p++) begin
         wait_idle();
         m = (p < 4) ? phase_order[p] : mode_type'($urandom_range(0, 3));
         write_mode(m);
         for (int i = 0; i < ItemsPerPhase; i++) begin
            if ($urandom_range(0, 99) == 0) wait_idle();
            send_random_item();
         end
      end

      wait_idle();
      $display("Ran %0d readout words under %0d format mode settings: %0d hits, %0d markers",
               items_sent, mode_writes, hits_seen, markers_seen);
      $display("Markers with sequence error: %0d, with timestamp wrap: %0d",
               seq_errs_seen, wraps_seen);
      if (mismatches == 0 && outstanding == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
